>>> hw/rtl/vertical_swipe_gesture_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertical swipe gesture detector
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VERTICAL_SWIPE_GESTURE_DETECTOR_ASSERT_SVH
`define VERTICAL_SWIPE_GESTURE_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define VSGD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VSGD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VSGD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define VSGD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

>>> hw/rtl/vsgd_pkg.sv
// ----------------------------------------------------------------------------
// Vertical swipe gesture detector package
// Payload types, register indexes, gesture codes and reset values.
// ----------------------------------------------------------------------------
package vsgd_pkg;

    // One touch report.
    typedef struct packed {
        logic        touch_down;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [31:0] time_ms;
    } touch_in_t;

    // One classification result.
    typedef struct packed {
        logic [1:0] gesture;
        logic       suppressed;
    } gesture_out_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_TOP_EDGE       = 3'd0;
    localparam logic [2:0] REG_BOTTOM_EDGE    = 3'd1;
    localparam logic [2:0] REG_MIN_VERT       = 3'd2;
    localparam logic [2:0] REG_MIN_DURATION   = 3'd3;
    localparam logic [2:0] REG_MAX_DURATION   = 3'd4;
    localparam logic [2:0] REG_COOLDOWN       = 3'd5;

    // Gesture codes.
    localparam logic [1:0] SWIPE_NONE = 2'd0;
    localparam logic [1:0] SWIPE_UP   = 2'd1;
    localparam logic [1:0] SWIPE_DOWN = 2'd2;

    // Register reset values.
    localparam logic [11:0] TOP_EDGE_RST     = 12'd36;
    localparam logic [11:0] BOTTOM_EDGE_RST  = 12'd235;
    localparam logic [11:0] MIN_VERT_RST     = 12'd180;
    localparam logic [15:0] MIN_DURATION_RST = 16'd120;
    localparam logic [15:0] MAX_DURATION_RST = 16'd2200;
    localparam logic [15:0] COOLDOWN_RST     = 16'd3000;

endpackage

>>> hw/rtl/vertical_swipe_gesture_detector.sv
// ----------------------------------------------------------------------------
// Vertical swipe gesture detector
// Two register stages, input and result, lie between a report and its result.
// Throughput: one report per cycle while the output is not stalled; the stroke
// state updates in the same cycle that moves a report from the input register
// to the result register.
// Reset (aresetn low, synchronous): registers return to defaults, the stroke
// and cooldown state clear, and both pipeline stages empty.
// ----------------------------------------------------------------------------
`include "vertical_swipe_gesture_detector_assert.svh"

module vertical_swipe_gesture_detector
    import vsgd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_valid,
    output logic          s_ready,
    input  touch_in_t     s_data,

    output logic          m_valid,
    input  logic          m_ready,
    output gesture_out_t  m_data,

    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    // Configuration registers.
    logic [11:0] top_edge_reg;
    logic [11:0] bottom_edge_reg;
    logic [11:0] min_vert_reg;
    logic [15:0] min_dur_reg;
    logic [15:0] max_dur_reg;
    logic [15:0] cooldown_reg;

    // Stroke state.
    logic        tracking_reg,     tracking_next;
    logic [11:0] start_x_reg,      start_x_next;
    logic [11:0] start_y_reg,      start_y_next;
    logic [31:0] start_time_reg,   start_time_next;
    logic [32:0] cooldown_end_reg, cooldown_end_next;

    // Pipeline registers.
    logic         in_valid_reg;
    touch_in_t    in_data_reg;
    logic         out_valid_reg;
    gesture_out_t out_data_reg, out_data_next;

    logic advance;

    // Classification terms.
    logic [12:0] dx, dy;
    logic [11:0] adx, ady;
    logic [13:0] adx_x4, ady_x3;
    logic [32:0] duration;
    logic        dur_ok, travel_ok, slope_ok, is_up, is_down;
    logic [1:0]  dir;
    logic        in_cooldown;

    // Handshakes: the input stage moves on whenever the result register frees up.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_edge_reg    <= TOP_EDGE_RST;
            bottom_edge_reg <= BOTTOM_EDGE_RST;
            min_vert_reg    <= MIN_VERT_RST;
            min_dur_reg     <= MIN_DURATION_RST;
            max_dur_reg     <= MAX_DURATION_RST;
            cooldown_reg    <= COOLDOWN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TOP_EDGE:     top_edge_reg    <= cfg_data[11:0];
                REG_BOTTOM_EDGE:  bottom_edge_reg <= cfg_data[11:0];
                REG_MIN_VERT:     min_vert_reg    <= cfg_data[11:0];
                REG_MIN_DURATION: min_dur_reg     <= cfg_data;
                REG_MAX_DURATION: max_dur_reg     <= cfg_data;
                REG_COOLDOWN:     cooldown_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stroke geometry, measured against the release report's point.
    always_comb begin
        dx       = {1'b0, in_data_reg.pos_x} - {1'b0, start_x_reg};
        dy       = {1'b0, in_data_reg.pos_y} - {1'b0, start_y_reg};
        adx      = dx[12] ? 12'(-dx) : dx[11:0];
        ady      = dy[12] ? 12'(-dy) : dy[11:0];
        adx_x4   = {adx, 2'b00};
        ady_x3   = {2'b00, ady} + {1'b0, ady, 1'b0};
        duration = {1'b0, in_data_reg.time_ms} - {1'b0, start_time_reg};

        // A negative duration fails the lower bound.
        dur_ok    = !duration[32]
                    && (duration[31:0] >= {16'd0, min_dur_reg})
                    && (duration[31:0] <= {16'd0, max_dur_reg});
        travel_ok = ady >= min_vert_reg;
        slope_ok  = adx_x4 <= ady_x3;
        is_up     = (start_y_reg >= bottom_edge_reg) && (in_data_reg.pos_y <= top_edge_reg)
                    && dy[12];
        is_down   = (start_y_reg <= top_edge_reg) && (in_data_reg.pos_y >= bottom_edge_reg)
                    && !dy[12] && (dy != 13'd0);

        if (!(dur_ok && travel_ok && slope_ok)) begin
            dir = SWIPE_NONE;
        end else if (is_up) begin
            dir = SWIPE_UP;
        end else if (is_down) begin
            dir = SWIPE_DOWN;
        end else begin
            dir = SWIPE_NONE;
        end

        in_cooldown = {1'b0, in_data_reg.time_ms} < cooldown_end_reg;
    end

    // Next stroke state and result for the report in the input register.
    always_comb begin
        tracking_next     = tracking_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        start_time_next   = start_time_reg;
        cooldown_end_next = cooldown_end_reg;
        out_data_next     = '{gesture: SWIPE_NONE, suppressed: 1'b0};

        if (in_data_reg.touch_down && !tracking_reg) begin
            // Press: latch the start point and time.
            tracking_next   = 1'b1;
            start_x_next    = in_data_reg.pos_x;
            start_y_next    = in_data_reg.pos_y;
            start_time_next = in_data_reg.time_ms;
        end else if (!in_data_reg.touch_down && tracking_reg) begin
            // Release: classify, then emit or suppress.
            tracking_next = 1'b0;
            if (dir != SWIPE_NONE) begin
                if (in_cooldown) begin
                    out_data_next.suppressed = 1'b1;
                end else begin
                    out_data_next.gesture = dir;
                    cooldown_end_next     = {1'b0, in_data_reg.time_ms}
                                            + {17'd0, cooldown_reg};
                end
            end
        end
    end

    // Stroke state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracking_reg     <= 1'b0;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            start_time_reg   <= '0;
            cooldown_end_reg <= '0;
        end else if (advance) begin
            tracking_reg     <= tracking_next;
            start_x_reg      <= start_x_next;
            start_y_reg      <= start_y_next;
            start_time_reg   <= start_time_next;
            cooldown_end_reg <= cooldown_end_next;
        end
    end

    // Input register: takes a transfer whenever it is empty or draining.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // A result never reports a gesture and a suppression together.
    `VSGD_ASSERT_IMPL(a_excl_result, aclk, aresetn, m_valid,
        !(m_data.suppressed && (m_data.gesture != SWIPE_NONE)),
        "gesture and suppressed both set")

    // Backpressure only when both stages are full and the output is stalled.
    `VSGD_ASSERT_IMPL(a_ready_low, aclk, aresetn, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready,
        "input stalled without a full pipeline")

    // Tracking ends only by a release report moving through.
    `VSGD_ASSERT_IMPL(a_track_fall, aclk, aresetn, $fell(tracking_reg),
        $past(advance) && !$past(in_data_reg.touch_down),
        "tracking cleared without a release")

    // An emitted gesture re-arms the cooldown from the release time.
    `VSGD_ASSERT_NEXT(a_cooldown_arm, aclk, aresetn,
        advance && (out_data_next.gesture != SWIPE_NONE),
        cooldown_end_reg == ({1'b0, $past(in_data_reg.time_ms)}
                             + {17'd0, $past(cooldown_reg)}),
        "cooldown not re-armed after emission")

endmodule
